[rtl/wmtc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Widescreen margin tile cache package
// Shared codes, defaults and record layouts of the margin tile cache.
// ----------------------------------------------------------------------------
package wmtc_pkg;

  // Default cache geometry (both must be powers of two)
  localparam int unsigned CACHE_COLS_DEF = 64;
  localparam int unsigned CACHE_ROWS_DEF = 32;

  // Item kinds carried in tuser
  localparam logic [1:0] KIND_FILL   = 2'd0;
  localparam logic [1:0] KIND_CAMERA = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_PROBE  = 2'd3;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W  = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_Y = 8'd1;
  localparam logic [7:0] FINE_X_RST = 8'd12;
  localparam logic [7:0] FINE_Y_RST = 8'd14;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 56;

  // Layer codes of a lookup
  localparam logic [1:0] LAYER_NONE = 2'd0;
  localparam logic [1:0] LAYER_ONE  = 2'd1;
  localparam logic [1:0] LAYER_TWO  = 2'd2;
  localparam logic [1:0] LAYER_THREE = 2'd3;

  // One slot of the cache memory
  typedef struct packed {
    logic        valid;
    logic [15:0] tag_y;
    logic [15:0] tag_x;
    logic [15:0] entry3;
    logic [15:0] entry2;
    logic [15:0] entry1;
  } store_word_t;

  // One accepted input item
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] world_x;
    logic signed [15:0] world_y;
    logic [15:0]        entry_layer1;
    logic [15:0]        entry_layer2;
    logic [15:0]        entry_layer3;
    logic               origin_ok;
    logic [1:0]         layer;
    logic signed [9:0]  pixel_x;
    logic [7:0]         pixel_y;
    logic [15:0]        scroll_h;
    logic [15:0]        scroll_v;
  } item_t;

  // Item information that travels alongside the memory read
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  layer;
    logic        cam_ok;
    logic [15:0] tile_x;
    logic [15:0] tile_y;
  } read_meta_t;

endpackage
`default_nettype wire

[rtl/wmtc_coord.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Margin tile coordinate unit
// Works out the world tile under a screen pixel from scroll, fine offset and
// camera origin, wrapped to 16 bits per axis.
// ----------------------------------------------------------------------------
module wmtc_coord (
  input  wire logic [15:0]        scroll_h_i,
  input  wire logic [15:0]        scroll_v_i,
  input  wire logic signed [9:0]  pixel_x_i,
  input  wire logic [7:0]         pixel_y_i,
  input  wire logic [7:0]         fine_x_i,
  input  wire logic [7:0]         fine_y_i,
  input  wire logic [15:0]        cam_x_i,
  input  wire logic [15:0]        cam_y_i,
  output logic [15:0]             tile_x_o,
  output logic [15:0]             tile_y_o
);

  // Snap the fine origin modulo 32 to the window nearest the camera origin.
  // The distance is taken as a signed 5-bit value; at the tie it goes to +16
  // when the raw distance is not negative.
  function automatic logic [15:0] snap_axis(input logic [4:0] scroll_tile,
                                            input logic [7:0] fine_ofs,
                                            input logic [15:0] cam);
    logic [8:0]  fine;
    logic [17:0] delta;
    logic        pos_tie;
    logic [15:0] step;
    fine    = {4'b0, scroll_tile} + {1'b0, fine_ofs};
    delta   = {9'b0, fine} - {{2{cam[15]}}, cam};
    pos_tie = (delta[4:0] == 5'b10000) && !delta[17];
    step    = pos_tie ? 16'd16 : {{11{delta[4]}}, delta[4:0]};
    return cam + step;
  endfunction

  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [17:0] pix_sum_x;
  logic [16:0] pix_sum_y;
  logic [15:0] ofs_x;
  logic [15:0] ofs_y;

  // Snap both axes
  assign origin_x = snap_axis(scroll_h_i[7:3], fine_x_i, cam_x_i);
  assign origin_y = snap_axis(scroll_v_i[7:3], fine_y_i, cam_y_i);

  // Floor-divided pixel offsets: floor((scroll + pixel) / 8) - scroll / 8
  // The horizontal sum spans -512 to 66046, so keep it as 18-bit signed
  assign pix_sum_x = {2'b0, scroll_h_i} + {{8{pixel_x_i[9]}}, pixel_x_i};
  assign pix_sum_y = {1'b0, scroll_v_i} + {9'b0, pixel_y_i};
  assign ofs_x = {pix_sum_x[17], pix_sum_x[17:3]} - {3'b0, scroll_h_i[15:3]};
  assign ofs_y = {2'b0, pix_sum_y[16:3]} - {3'b0, scroll_v_i[15:3]};

  assign tile_x_o = origin_x + ofs_x;
  assign tile_y_o = origin_y + ofs_y;

endmodule
`default_nettype wire

[rtl/wmtc_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Margin tile cache store
// Slot memory with one write and one registered read port, plus the pass
// that clears every valid mark after reset.
// ----------------------------------------------------------------------------
module wmtc_store #(
  parameter int unsigned SLOT_W = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [SLOT_W-1:0]        rd_addr_i,
  input  wire logic                     wr_en_i,
  input  wire logic [SLOT_W-1:0]        wr_addr_i,
  input  wire wmtc_pkg::store_word_t    wr_data_i,
  output wmtc_pkg::store_word_t         rd_data_o,
  output logic                          busy_o
);

  localparam int unsigned DEPTH = 1 << SLOT_W;

  wmtc_pkg::store_word_t mem [DEPTH];
  wmtc_pkg::store_word_t rd_data_q;

  logic              clr_active_q, clr_active_d;
  logic [SLOT_W-1:0] clr_cnt_q, clr_cnt_d;

  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_waddr;
  wmtc_pkg::store_word_t mem_wdata;

  // Sweep every slot once after reset
  always_comb begin
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == {SLOT_W{1'b1}}) begin
        clr_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
    end
  end

  // Select the clearing pass or the fill write
  always_comb begin
    mem_we    = wr_en_i;
    mem_waddr = wr_addr_i;
    mem_wdata = wr_data_i;
    if (clr_active_q) begin
      mem_we          = 1'b1;
      mem_waddr       = clr_cnt_q;
      mem_wdata       = '0;
      mem_wdata.tag_x = 16'hFFFF;
      mem_wdata.tag_y = 16'hFFFF;
    end
  end

  // Memory write and registered read; read data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_active_q;

endmodule
`default_nettype wire

[rtl/widescreen_margin_tile_cache_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Widescreen margin tile cache
// Direct-mapped cache of background tilemap entries for the margin pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis channel; tuser carries the kind (fill, set
//   camera, lookup, probe) and tdata the remaining fields. Every item gives
//   exactly one result on m_axis, in order. Fine offsets are written on the
//   cfg channel (index 0 horizontal, index 1 vertical) while the block idles;
//   cfg_ready_o is always high.
//   Throughput: one item per cycle while the result side takes results and no
//   clearing pass runs; a three-stage pipe (coordinate stage, memory read,
//   result register) with one slot-memory read port and one write port.
//   Fills write at the stage where lookups read, so a lookup right behind a
//   fill of the same slot sees the new data.
//   Reset: the camera becomes invalid, fine offsets return to 12 and 14, and
//   a clearing pass over all CACHE_COLS * CACHE_ROWS slots (2048 by default)
//   marks every slot empty; s_axis_tready stays low during the pass.
//   Stall: when m_axis_tready is low the result holds, and the pipe keeps
//   accepting items until its two inner stages are full.
// ----------------------------------------------------------------------------
module widescreen_margin_tile_cache_top #(
  parameter int unsigned CACHE_COLS = wmtc_pkg::CACHE_COLS_DEF,
  parameter int unsigned CACHE_ROWS = wmtc_pkg::CACHE_ROWS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input item channel
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata from bit 0: world_x[16], world_y[16], entry_layer1[16],
  // entry_layer2[16], entry_layer3[16], origin_ok[1], layer[2],
  // pixel_x[10], pixel_y[8], scroll_h[16], scroll_v[16], zero pad[3]
  input  wire logic [wmtc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: kind[2]
  input  wire logic [1:0]                        s_axis_tuser,
  // Result channel
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata from bit 0: hit[1], entry_out[16], tile_x[16], tile_y[16],
  // zero pad[7]
  output logic [wmtc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // Configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [wmtc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [7:0]                        cfg_data_i
);

  localparam int unsigned COL_W  = $clog2(CACHE_COLS);
  localparam int unsigned ROW_W  = $clog2(CACHE_ROWS);
  localparam int unsigned SLOT_W = COL_W + ROW_W;

  // Configuration and camera state
  logic [7:0]  fine_x_q, fine_y_q;
  logic [15:0] cam_x_q, cam_y_q;
  logic        cam_ok_q;

  // Pipeline state
  logic                 s1_v_q, s2_v_q, out_v_q;
  wmtc_pkg::item_t      s1_q;
  wmtc_pkg::read_meta_t s2_q;
  logic                 hit_q;
  logic [15:0]          entry_q, tile_x_q, tile_y_q;

  logic                 out_free, s2_free, s1_move, s1_free, in_take;
  logic                 store_busy;
  wmtc_pkg::item_t      in_item;
  wmtc_pkg::read_meta_t s1_meta;
  wmtc_pkg::store_word_t rd_word, wr_word;
  logic [15:0]          calc_x, calc_y;
  logic [SLOT_W-1:0]    s1_slot;
  logic                 fill_we;
  logic                 tag_match;
  logic                 hit_d;
  logic [15:0]          entry_d, tile_x_d, tile_y_d;

  // Unpack the input transaction
  assign in_item.kind         = s_axis_tuser;
  assign in_item.world_x      = s_axis_tdata[15:0];
  assign in_item.world_y      = s_axis_tdata[31:16];
  assign in_item.entry_layer1 = s_axis_tdata[47:32];
  assign in_item.entry_layer2 = s_axis_tdata[63:48];
  assign in_item.entry_layer3 = s_axis_tdata[79:64];
  assign in_item.origin_ok    = s_axis_tdata[80];
  assign in_item.layer        = s_axis_tdata[82:81];
  assign in_item.pixel_x      = s_axis_tdata[92:83];
  assign in_item.pixel_y      = s_axis_tdata[100:93];
  assign in_item.scroll_h     = s_axis_tdata[116:101];
  assign in_item.scroll_v     = s_axis_tdata[132:117];

  // Flow control: a stage moves on when the next one is empty or moving
  assign out_free      = !out_v_q || m_axis_tready;
  assign s2_free       = !s2_v_q || out_free;
  assign s1_move       = s1_v_q && s2_free;
  assign s1_free       = !s1_v_q || s2_free;
  assign s_axis_tready = s1_free && !store_busy;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Coordinate stage
  wmtc_coord u_coord (
    .scroll_h_i (s1_q.scroll_h),
    .scroll_v_i (s1_q.scroll_v),
    .pixel_x_i  (s1_q.pixel_x),
    .pixel_y_i  (s1_q.pixel_y),
    .fine_x_i   (fine_x_q),
    .fine_y_i   (fine_y_q),
    .cam_x_i    (cam_x_q),
    .cam_y_i    (cam_y_q),
    .tile_x_o   (calc_x),
    .tile_y_o   (calc_y)
  );

  // Pick the tile that addresses the store
  always_comb begin
    s1_meta.kind   = s1_q.kind;
    s1_meta.layer  = s1_q.layer;
    s1_meta.cam_ok = cam_ok_q;
    if (s1_q.kind == wmtc_pkg::KIND_LOOKUP) begin
      s1_meta.tile_x = calc_x;
      s1_meta.tile_y = calc_y;
    end else begin
      s1_meta.tile_x = s1_q.world_x;
      s1_meta.tile_y = s1_q.world_y;
    end
  end

  assign s1_slot = {s1_meta.tile_y[ROW_W-1:0], s1_meta.tile_x[COL_W-1:0]};
  assign fill_we = s1_move && (s1_q.kind == wmtc_pkg::KIND_FILL);

  always_comb begin
    wr_word.valid  = 1'b1;
    wr_word.tag_y  = s1_q.world_y;
    wr_word.tag_x  = s1_q.world_x;
    wr_word.entry3 = s1_q.entry_layer3;
    wr_word.entry2 = s1_q.entry_layer2;
    wr_word.entry1 = s1_q.entry_layer1;
  end

  wmtc_store #(
    .SLOT_W (SLOT_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_move),
    .rd_addr_i (s1_slot),
    .wr_en_i   (fill_we),
    .wr_addr_i (s1_slot),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word),
    .busy_o    (store_busy)
  );

  // Resolve the result from the read slot
  assign tag_match = rd_word.valid && (rd_word.tag_x == s2_q.tile_x)
                     && (rd_word.tag_y == s2_q.tile_y);

  always_comb begin
    hit_d    = 1'b0;
    entry_d  = '0;
    tile_x_d = '0;
    tile_y_d = '0;
    case (s2_q.kind)
      wmtc_pkg::KIND_PROBE: begin
        hit_d    = tag_match;
        tile_x_d = s2_q.tile_x;
        tile_y_d = s2_q.tile_y;
      end
      wmtc_pkg::KIND_LOOKUP: begin
        hit_d    = tag_match && s2_q.cam_ok && (s2_q.layer != wmtc_pkg::LAYER_NONE);
        tile_x_d = s2_q.tile_x;
        tile_y_d = s2_q.tile_y;
        if (hit_d) begin
          case (s2_q.layer)
            wmtc_pkg::LAYER_ONE:   entry_d = rd_word.entry1;
            wmtc_pkg::LAYER_TWO:   entry_d = rd_word.entry2;
            wmtc_pkg::LAYER_THREE: entry_d = rd_word.entry3;
            default:               entry_d = '0;
          endcase
        end
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
  end

  // Advance pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= in_take;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_item;
    end
    if (s1_move) begin
      s2_q <= s1_meta;
    end
    if (out_free && s2_v_q) begin
      hit_q    <= hit_d;
      entry_q  <= entry_d;
      tile_x_q <= tile_x_d;
      tile_y_q <= tile_y_d;
    end
  end

  // Camera origin and fine offset registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q  <= '0;
      cam_y_q  <= '0;
      cam_ok_q <= 1'b0;
      fine_x_q <= wmtc_pkg::FINE_X_RST;
      fine_y_q <= wmtc_pkg::FINE_Y_RST;
    end else begin
      if (s1_move && (s1_q.kind == wmtc_pkg::KIND_CAMERA)) begin
        cam_x_q  <= s1_q.world_x;
        cam_y_q  <= s1_q.world_y;
        cam_ok_q <= s1_q.origin_ok;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == wmtc_pkg::CFG_FINE_X) begin
          fine_x_q <= cfg_data_i;
        end else if (cfg_index_i == wmtc_pkg::CFG_FINE_Y) begin
          fine_y_q <= cfg_data_i;
        end
      end
    end
  end

  // Drive the result channel
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'b0, tile_y_q, tile_x_q, entry_q, hit_q};

  // Checks
  a_no_take_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> !in_take)
    else $error("item accepted during the clearing pass");

  a_no_fill_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> !fill_we)
    else $error("fill write collides with the clearing pass");

  a_miss_has_no_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !hit_q) |-> (entry_q == 16'd0))
    else $error("entry reported without a hit");

  a_s2_held_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !out_free) |=> (s2_v_q && $stable(s2_q)))
    else $error("read stage lost its item while the output stalled");

endmodule
`default_nettype wire

[tb/margin_cache_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Margin tile cache checker
// Watches the item, result and configuration channels of the margin tile
// cache. Keeps its own copy of the slot store, the camera and the fine
// offsets, predicts one result per accepted item and compares each result
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module margin_cache_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Item channel: tdata fields as on the block, tuser holds the kind
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [wmtc_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic [1:0]                       in_user_i,
  // Result channel: hit, entry_out, tile_x, tile_y from bit 0
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [wmtc_pkg::OUT_TDATA_W-1:0] out_data_i,
  // Configuration channel
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [wmtc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]                       cfg_data_i,
  // Status for the stimulus side
  output int unsigned                      mismatch_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      results_o,
  output int unsigned                      lookup_hits_o,
  output int unsigned                      probe_hits_o
);

  localparam int unsigned COLS       = wmtc_pkg::CACHE_COLS_DEF;
  localparam int unsigned ROWS       = wmtc_pkg::CACHE_ROWS_DEF;
  localparam int unsigned SLOT_COUNT = COLS * ROWS;

  // One predicted or observed result; kind is kept for statistics only
  typedef struct packed {
    logic [1:0]  kind;
    logic        hit;
    logic [15:0] entry;
    logic [15:0] tile_x;
    logic [15:0] tile_y;
  } tile_result_t;

  logic [2:0][15:0] slot_entries [SLOT_COUNT];
  logic             slot_valid   [SLOT_COUNT];
  logic [31:0]      slot_tags    [SLOT_COUNT];
  int               camera_x;
  int               camera_y;
  logic             camera_ok;
  logic [7:0]       fine_x;
  logic [7:0]       fine_y;

  tile_result_t     expected_results [$];
  tile_result_t     want;
  tile_result_t     got;
  wmtc_pkg::item_t  accepted_item;
  int unsigned      mismatches;
  int unsigned      results_seen;
  int unsigned      lookup_hits;
  int unsigned      probe_hits;

  function automatic int unsigned slot_of_tile(input logic [15:0] tx, input logic [15:0] ty);
    return (32'(ty) & (ROWS - 1)) * COLS + (32'(tx) & (COLS - 1));
  endfunction

  // Snap a fine origin to the 32-tile window nearest the camera origin
  function automatic int snap_to_camera(input int fine_pos, input int coarse);
    int delta;
    int rem;
    delta = fine_pos - coarse;
    rem   = ((delta + 16) & 31) - 16;
    // a distance of exactly half a window goes up only from the positive side
    if (rem == -16) begin
      rem = (delta >= 16) ? 16 : -16;
    end
    return coarse + rem;
  endfunction

  // Apply one item to the cache copy and return the result it causes
  function automatic tile_result_t predict_result(input wmtc_pkg::item_t it);
    tile_result_t res;
    int unsigned  slot;
    int           hofs;
    int           vofs;
    int           px;
    int           py;
    int           origin_x;
    int           origin_y;
    int           full_x;
    int           full_y;
    res      = '0;
    res.kind = it.kind;
    case (it.kind)
      wmtc_pkg::KIND_FILL: begin
        slot = slot_of_tile(it.world_x, it.world_y);
        slot_entries[slot] = {it.entry_layer3, it.entry_layer2, it.entry_layer1};
        slot_valid[slot]   = 1'b1;
        slot_tags[slot]    = {it.world_y, it.world_x};
      end
      wmtc_pkg::KIND_CAMERA: begin
        camera_x  = $signed(it.world_x);
        camera_y  = $signed(it.world_y);
        camera_ok = it.origin_ok;
      end
      wmtc_pkg::KIND_PROBE: begin
        slot       = slot_of_tile(it.world_x, it.world_y);
        res.hit    = slot_valid[slot] && (slot_tags[slot] == {it.world_y, it.world_x});
        res.tile_x = it.world_x;
        res.tile_y = it.world_y;
      end
      wmtc_pkg::KIND_LOOKUP: begin
        hofs     = int'(it.scroll_h);
        vofs     = int'(it.scroll_v);
        px       = $signed(it.pixel_x);
        py       = int'(it.pixel_y);
        origin_x = snap_to_camera(((hofs >> 3) & 31) + int'(fine_x), camera_x);
        origin_y = snap_to_camera(((vofs >> 3) & 31) + int'(fine_y), camera_y);
        // arithmetic shift is a floor division by the tile width
        full_x     = origin_x + ((hofs + px) >>> 3) - (hofs >>> 3);
        full_y     = origin_y + ((vofs + py) >>> 3) - (vofs >>> 3);
        res.tile_x = full_x[15:0];
        res.tile_y = full_y[15:0];
        slot       = slot_of_tile(res.tile_x, res.tile_y);
        if (camera_ok && it.layer != wmtc_pkg::LAYER_NONE && slot_valid[slot]
            && slot_tags[slot] == {res.tile_y, res.tile_x}) begin
          res.hit = 1'b1;
          case (it.layer)
            wmtc_pkg::LAYER_ONE:   res.entry = slot_entries[slot][0];
            wmtc_pkg::LAYER_TWO:   res.entry = slot_entries[slot][1];
            wmtc_pkg::LAYER_THREE: res.entry = slot_entries[slot][2];
            default:               res.entry = '0;
          endcase
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // clear the store copy, the camera and the offsets
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_entries[i] = '0;
        slot_valid[i]   = 1'b0;
        slot_tags[i]    = '1;
      end
      camera_x     = 0;
      camera_y     = 0;
      camera_ok    = 1'b0;
      fine_x       = wmtc_pkg::FINE_X_RST;
      fine_y       = wmtc_pkg::FINE_Y_RST;
      mismatches   = 0;
      results_seen = 0;
      lookup_hits  = 0;
      probe_hits   = 0;
      expected_results.delete();
    end else begin
      // track offset writes
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == wmtc_pkg::CFG_FINE_X) begin
          fine_x = cfg_data_i;
        end else if (cfg_index_i == wmtc_pkg::CFG_FINE_Y) begin
          fine_y = cfg_data_i;
        end
      end

      // compare each result transaction with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got.kind   = '0;
        got.hit    = out_data_i[0];
        got.entry  = out_data_i[16:1];
        got.tile_x = out_data_i[32:17];
        got.tile_y = out_data_i[48:33];
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, actual hit %0d entry %h tile %h,%h",
                   $time, got.hit, got.entry, got.tile_x, got.tile_y);
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 16'(want.hit), 16'(got.hit));
          check_field("entry_out", want.entry, got.entry);
          check_field("tile_x", want.tile_x, got.tile_x);
          check_field("tile_y", want.tile_y, got.tile_y);
          if (want.hit && want.kind == wmtc_pkg::KIND_LOOKUP) begin
            lookup_hits++;
          end
          if (want.hit && want.kind == wmtc_pkg::KIND_PROBE) begin
            probe_hits++;
          end
        end
      end

      // predict each accepted item transaction
      if (in_valid_i && in_ready_i) begin
        accepted_item.kind         = in_user_i;
        accepted_item.world_x      = in_data_i[15:0];
        accepted_item.world_y      = in_data_i[31:16];
        accepted_item.entry_layer1 = in_data_i[47:32];
        accepted_item.entry_layer2 = in_data_i[63:48];
        accepted_item.entry_layer3 = in_data_i[79:64];
        accepted_item.origin_ok    = in_data_i[80];
        accepted_item.layer        = in_data_i[82:81];
        accepted_item.pixel_x      = in_data_i[92:83];
        accepted_item.pixel_y      = in_data_i[100:93];
        accepted_item.scroll_h     = in_data_i[116:101];
        accepted_item.scroll_v     = in_data_i[132:117];
        expected_results.push_back(predict_result(accepted_item));
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_results.size();
    results_o        <= results_seen;
    lookup_hits_o    <= lookup_hits;
    probe_hits_o     <= probe_hits;
  end

endmodule

[tb/widescreen_margin_tile_cache_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Widescreen margin tile cache testbench
// Drives directed corner items and then scenes of camera, fill, lookup and
// probe items through the cache under several fine offsets and handshake
// idling patterns. The checker beside the block predicts and compares every
// result; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module widescreen_margin_tile_cache_top_test;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [wmtc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]                       s_axis_tuser  = wmtc_pkg::KIND_FILL;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [wmtc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             cfg_valid     = 1'b0;
  logic                             cfg_ready;
  logic [wmtc_pkg::CFG_IDX_W-1:0]   cfg_index     = wmtc_pkg::CFG_FINE_X;
  logic [7:0]                       cfg_data      = '0;

  int unsigned            mismatch_count;
  int unsigned            results_pending;
  int unsigned            results_checked;
  int unsigned            lookup_hits;
  int unsigned            probe_hits;
  int unsigned            send_idle_pct = 0;
  int unsigned            recv_idle_pct = 0;
  int unsigned            items_sent    = 0;
  logic [7:0]             fine_x        = wmtc_pkg::FINE_X_RST;
  logic [7:0]             fine_y        = wmtc_pkg::FINE_Y_RST;

  widescreen_margin_tile_cache_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  margin_cache_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_user_i        (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_pending),
    .results_o        (results_checked),
    .lookup_hits_o    (lookup_hits),
    .probe_hits_o     (probe_hits)
  );

  always #4 clk_i = ~clk_i;

  // Stall the result side at the current idle rate
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic wmtc_pkg::item_t random_item();
    wmtc_pkg::item_t it;
    it.kind         = 2'($urandom);
    it.world_x      = 16'($urandom);
    it.world_y      = 16'($urandom);
    it.entry_layer1 = 16'($urandom);
    it.entry_layer2 = 16'($urandom);
    it.entry_layer3 = 16'($urandom);
    it.origin_ok    = 1'($urandom);
    it.layer        = 2'($urandom);
    it.pixel_x      = 10'(int'($urandom_range(767)) - 256);
    it.pixel_y      = 8'($urandom);
    it.scroll_h     = 16'($urandom);
    it.scroll_v     = 16'($urandom);
    return it;
  endfunction

  // Unused fields stay random so that the block is seen to ignore them
  function automatic wmtc_pkg::item_t make_fill(input logic [15:0] wx, input logic [15:0] wy,
                                                input logic [15:0] e1, input logic [15:0] e2,
                                                input logic [15:0] e3);
    wmtc_pkg::item_t it;
    it              = random_item();
    it.kind         = wmtc_pkg::KIND_FILL;
    it.world_x      = wx;
    it.world_y      = wy;
    it.entry_layer1 = e1;
    it.entry_layer2 = e2;
    it.entry_layer3 = e3;
    return it;
  endfunction

  function automatic wmtc_pkg::item_t make_camera(input logic [15:0] wx,
                                                  input logic [15:0] wy, input logic ok);
    wmtc_pkg::item_t it;
    it           = random_item();
    it.kind      = wmtc_pkg::KIND_CAMERA;
    it.world_x   = wx;
    it.world_y   = wy;
    it.origin_ok = ok;
    return it;
  endfunction

  function automatic wmtc_pkg::item_t make_probe(input logic [15:0] wx, input logic [15:0] wy);
    wmtc_pkg::item_t it;
    it         = random_item();
    it.kind    = wmtc_pkg::KIND_PROBE;
    it.world_x = wx;
    it.world_y = wy;
    return it;
  endfunction

  function automatic wmtc_pkg::item_t make_lookup(input logic [1:0] layer,
                                                  input logic [9:0] px,
                                                  input logic [7:0] py,
                                                  input logic [15:0] sh,
                                                  input logic [15:0] sv);
    wmtc_pkg::item_t it;
    it          = random_item();
    it.kind     = wmtc_pkg::KIND_LOOKUP;
    it.layer    = layer;
    it.pixel_x  = px;
    it.pixel_y  = py;
    it.scroll_h = sh;
    it.scroll_v = sv;
    return it;
  endfunction

  // Idle at random, then present one item transaction and wait for it to be taken
  task automatic send_item(input wmtc_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {3'b000, it.scroll_v, it.scroll_h, it.pixel_y, it.pixel_x, it.layer,
                      it.origin_ok, it.entry_layer3, it.entry_layer2, it.entry_layer1,
                      it.world_y, it.world_x};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Hold the item side until every expected result has been taken
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_fine_offsets(input logic [7:0] fx, input logic [7:0] fy);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= wmtc_pkg::CFG_FINE_X;
    cfg_data  <= fx;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= wmtc_pkg::CFG_FINE_Y;
    cfg_data  <= fy;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fine_x = fx;
    fine_y = fy;
  endtask

  initial begin
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic [15:0]        scroll_h;
    logic [15:0]        scroll_v;
    int                 off_x;
    int                 off_y;
    int                 col_sel;
    int                 row_sel;
    int unsigned        target;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset offsets, no idling
    send_item(make_lookup(wmtc_pkg::LAYER_ONE, 10'sd0, 8'd0, 16'h0000, 16'h0000));
    // all-ones coordinate matches the reset tag but the slot is still empty
    send_item(make_probe(16'hFFFF, 16'hFFFF));
    send_item(make_probe(16'h0000, 16'h0000));
    send_item(make_fill(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000));
    send_item(make_probe(16'hFFFF, 16'hFFFF));
    // same slot, other tag
    send_item(make_probe(16'd63, 16'd31));
    send_item(make_fill(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h5A5A));
    send_item(make_probe(16'h7FFF, 16'h8000));
    send_item(make_camera(16'h0000, 16'h0000, 1'b1));
    send_item(make_fill(16'd12, 16'd14, 16'hFFFF, 16'h0001, 16'h8000));
    // lookups right behind the fill of their slot, every layer
    send_item(make_lookup(wmtc_pkg::LAYER_ONE, 10'sd0, 8'd0, 16'h0000, 16'h0000));
    send_item(make_lookup(wmtc_pkg::LAYER_TWO, 10'sd0, 8'd0, 16'h0000, 16'h0000));
    send_item(make_lookup(wmtc_pkg::LAYER_THREE, 10'sd0, 8'd0, 16'h0000, 16'h0000));
    send_item(make_lookup(wmtc_pkg::LAYER_NONE, 10'sd0, 8'd0, 16'h0000, 16'h0000));
    send_item(make_lookup(wmtc_pkg::LAYER_ONE, -10'sd256, 8'd255, 16'hFFFF, 16'hFFFF));
    // half-window distance from above the camera
    send_item(make_lookup(wmtc_pkg::LAYER_TWO, 10'sd511, 8'd0, 16'h0020, 16'h0000));
    // half-window distance from below on both axes
    send_item(make_camera(16'd28, 16'd30, 1'b1));
    send_item(make_lookup(wmtc_pkg::LAYER_ONE, 10'sd0, 8'd0, 16'h0000, 16'h0000));
    // world coordinates that wrap past both ends
    send_item(make_camera(16'h7FFF, 16'h7FFF, 1'b1));
    send_item(make_lookup(wmtc_pkg::LAYER_THREE, 10'sd511, 8'd255, 16'h0000, 16'h0000));
    send_item(make_camera(16'h8000, 16'h8000, 1'b1));
    send_item(make_lookup(wmtc_pkg::LAYER_ONE, -10'sd256, 8'd0, 16'hFFFF, 16'h0000));
    // scroll plus pixel crossing the top of the scroll range
    send_item(make_lookup(wmtc_pkg::LAYER_TWO, 10'sd511, 8'd255, 16'hFFFF, 16'hFFFF));
    // camera invalid: a filled tile must miss
    send_item(make_camera(16'h0000, 16'h0000, 1'b0));
    send_item(make_lookup(wmtc_pkg::LAYER_ONE, 10'sd0, 8'd0, 16'h0000, 16'h0000));
    send_item(make_probe(16'd12, 16'd14));

    // Random scenes under a sweep of fine offsets and idling patterns
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       write_fine_offsets(8'h00, 8'h00);
        1:       write_fine_offsets(8'hFF, 8'hFF);
        2:       write_fine_offsets(8'h00, 8'hFF);
        3:       write_fine_offsets(8'hFF, 8'h00);
        default: write_fine_offsets(8'($urandom), 8'($urandom));
      endcase
      send_idle_pct = (phase < 2) ? 32 : (phase < 4) ? 45 : 0;
      recv_idle_pct = (phase < 2) ? 45 : (phase < 4) ? 32 : 0;
      target = items_sent + 80;
      while (items_sent < target) begin
        if ($urandom_range(4) == 0) begin
          send_item(random_item());
        end else begin
          // set a valid camera and fill most of the window around it
          cam_x = 16'($urandom);
          cam_y = 16'($urandom);
          send_item(make_camera(cam_x, cam_y, 1'b1));
          for (int dy = -1; dy <= 2; dy++) begin
            for (int dx = -2; dx <= 2; dx++) begin
              if ($urandom_range(9) < 7) begin
                // now and then a tile that aliases onto the same slot
                off_x = ($urandom_range(9) == 0) ? int'(wmtc_pkg::CACHE_COLS_DEF) : 0;
                send_item(make_fill(16'(cam_x + dx + off_x), 16'(cam_y + dy),
                                    16'($urandom), 16'($urandom), 16'($urandom)));
              end
            end
          end
          // query the window, with a little noise mixed in
          repeat (20) begin
            if ($urandom_range(6) == 0) begin
              send_item(random_item());
            end else if ($urandom_range(3) == 0) begin
              send_item(make_probe(16'(cam_x + int'($urandom_range(4)) - 2),
                                   16'(cam_y + int'($urandom_range(3)) - 1)));
            end else begin
              // pick scroll so the fine origin lands next to the camera
              off_x = ($urandom_range(15) == 0) ? (($urandom_range(1) == 0) ? 16 : -16)
                                                : int'($urandom_range(2)) - 1;
              off_y = ($urandom_range(15) == 0) ? (($urandom_range(1) == 0) ? 16 : -16)
                                                : int'($urandom_range(2)) - 1;
              col_sel  = int'(cam_x) + off_x - int'(fine_x);
              row_sel  = int'(cam_y) + off_y - int'(fine_y);
              scroll_h = 16'($urandom);
              scroll_v = 16'($urandom);
              scroll_h[7:3] = col_sel[4:0];
              scroll_v[7:3] = row_sel[4:0];
              send_item(make_lookup(2'($urandom), 10'(int'($urandom_range(16)) - 8),
                                    8'($urandom_range(8)), scroll_h, scroll_v));
            end
          end
        end
      end
    end

    wait_for_results();
    $display("Sent %0d items: corner cases, half-window snaps, coordinate wrap, then",
             items_sent);
    $display("window scenes under 3 idling patterns; %0d results, %0d lookup hits, %0d probe hits",
             results_checked, lookup_hits, probe_hits);
    if (mismatch_count == 0) begin
      $display("widescreen_margin_tile_cache_top test passed");
    end else begin
      $display("widescreen_margin_tile_cache_top test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("widescreen_margin_tile_cache_top test failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/wmtc_pkg.sv
rtl/wmtc_coord.sv
rtl/wmtc_store.sv
rtl/widescreen_margin_tile_cache_top.sv
tb/margin_cache_checker.sv
tb/widescreen_margin_tile_cache_top_test.sv
